[sv/sfr_pkg.sv]
package sfr_pkg;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int BURST_DEPTH = 8;
  localparam int LEN_W = 4;
  localparam int TEXT_W = 64;

  typedef enum logic [1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TEXT_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]  pattern_length;
    logic [TEXT_W-1:0] replacement_bytes;
    logic [LEN_W-1:0]  replacement_length;
  } cfg_t;

  // result bytes caused by one input transfer
  typedef struct packed {
    logic [BURST_DEPTH-1:0][7:0] bytes;
    logic [LEN_W-1:0]            cnt;
    logic                        end_flag;
    logic                        marker;
  } burst_t;

endpackage

[sv/sfr_ifs.sv]
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  logic       byte_valid;
  logic       run_last;
  logic       result_end;

  modport source (output valid, output result_byte, output byte_valid, output run_last,
                  output result_end, input ready);
  modport sink (input valid, input result_byte, input byte_valid, input run_last,
                input result_end, output ready);
endinterface

interface sfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[sv/sfr_cfg_regs.sv]
module sfr_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  sfr_cfg_if.sink       cfg_ch,
  output sfr_pkg::cfg_t cfg,
  output logic          plen_wr
);

  sfr_pkg::cfg_t cfg_r;
  sfr_pkg::cfg_t cfg_nxt;
  logic          wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;

  always_comb begin
    cfg_nxt = cfg_r;
    plen_wr = 1'b0;
    if (wr) begin
      case (sfr_pkg::cfg_idx_t'(cfg_ch.index))
        sfr_pkg::CFG_PATTERN_BYTES: cfg_nxt.pattern_bytes = cfg_ch.wdata;
        sfr_pkg::CFG_PATTERN_LENGTH: begin
          cfg_nxt.pattern_length = cfg_ch.wdata[sfr_pkg::LEN_W-1:0];
          plen_wr = 1'b1;
        end
        sfr_pkg::CFG_REPLACEMENT_BYTES: cfg_nxt.replacement_bytes = cfg_ch.wdata;
        sfr_pkg::CFG_REPLACEMENT_LENGTH:
          cfg_nxt.replacement_length = cfg_ch.wdata[sfr_pkg::LEN_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/sfr_matcher.sv]
module sfr_matcher #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sfr_pkg::cfg_t   cfg,
  input  logic            plen_wr,
  input  logic            fire,
  input  logic [7:0]      text_byte,
  input  logic            text_end,
  output sfr_pkg::burst_t burst
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int LW = sfr_pkg::LEN_W;

  logic [7:0]    win_r   [MAX_PATTERN];
  logic [7:0]    win_nxt [MAX_PATTERN];
  logic [7:0]    w       [MAX_PATTERN];
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [LW-1:0] plen;
  logic [LW-1:0] rlen;
  logic          full;
  logic          match;

  assign plen = (cfg.pattern_length > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
                                                        : cfg.pattern_length;
  assign rlen = (cfg.replacement_length > LW'(sfr_pkg::BURST_DEPTH))
                ? LW'(sfr_pkg::BURST_DEPTH) : cfg.replacement_length;
  assign full = (LW'(cnt_r) + LW'(1)) == plen;

  // window with the new byte appended
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      w[i] = (CW'(i) == cnt_r) ? text_byte : win_r[i];
    end
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LW'(i) < plen) && (w[i] != cfg.pattern_bytes[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    burst          = '0;
    burst.end_flag = text_end;
    cnt_nxt        = cnt_r;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_nxt[i] = w[i];
    end
    if (plen == '0) begin
      burst.bytes[0] = text_byte;
      burst.cnt      = LW'(1);
    end else if (full && match) begin
      burst.bytes = cfg.replacement_bytes;
      burst.cnt   = rlen;
      cnt_nxt     = '0;
    end else begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        burst.bytes[i] = w[i];
      end
      if (full) begin
        // oldest byte leaves, rest flushed on string end
        burst.cnt = text_end ? plen : LW'(1);
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          win_nxt[i] = w[i+1];
        end
        win_nxt[MAX_PATTERN-1] = '0;
        cnt_nxt = text_end ? '0 : cnt_r;
      end else if (text_end) begin
        burst.cnt = LW'(cnt_r) + LW'(1);
        cnt_nxt   = '0;
      end else begin
        burst.cnt = '0;
        cnt_nxt   = cnt_r + CW'(1);
      end
    end
    if (text_end && burst.cnt == '0) begin
      burst.bytes  = '0;
      burst.cnt    = LW'(1);
      burst.marker = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (plen_wr) begin
      cnt_r <= '0;
    end else if (fire) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      win_r <= win_nxt;
    end
  end

endmodule

[sv/sfr_out_buf.sv]
module sfr_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  sfr_pkg::burst_t burst,
  output logic            in_ready,
  sfr_out_if.source       out_ch
);

  localparam int LW = sfr_pkg::LEN_W;

  logic [sfr_pkg::BURST_DEPTH-1:0][7:0] bytes_r;
  logic [sfr_pkg::BURST_DEPTH-1:0][7:0] bytes_nxt;
  logic [LW-1:0]                        cnt_r;
  logic [LW-1:0]                        cnt_nxt;
  logic                                 end_r;
  logic                                 marker_r;
  logic                                 pop;
  logic                                 last_one;

  assign last_one = cnt_r == LW'(1);
  assign pop      = out_ch.valid && out_ch.ready;
  assign in_ready = (cnt_r == '0) || (last_one && out_ch.ready);

  assign out_ch.valid       = cnt_r != '0;
  assign out_ch.result_byte = bytes_r[0];
  assign out_ch.byte_valid  = !marker_r;
  assign out_ch.run_last    = last_one;
  assign out_ch.result_end  = end_r && last_one;

  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      bytes_nxt = burst.bytes;
      cnt_nxt   = burst.cnt;
    end else if (pop) begin
      bytes_nxt = {8'h00, bytes_r[sfr_pkg::BURST_DEPTH-1:1]};
      cnt_nxt   = cnt_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (load) begin
      end_r    <= burst.end_flag;
      marker_r <= burst.marker;
    end
  end

endmodule

[sv/stream_find_replace_top.sv]
// timing: the first result of an input transfer is offered in the cycle after that transfer
// throughput: one input per cycle while each input gives at most one result and output
//   ready stays high; an input giving n results holds the output buffer until all are sent
// reset: synchronous, active low; clears config registers, window count and output buffer
module stream_find_replace_top #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sfr_in_if.sink    in_stream,
  sfr_out_if.source out_stream,
  sfr_cfg_if.sink   cfg_port
);

  sfr_pkg::cfg_t   cfg;
  sfr_pkg::burst_t burst;
  logic            plen_wr;
  logic            fire;
  logic            buf_ready;

  assign in_stream.ready = buf_ready;
  assign fire = in_stream.valid && buf_ready;

  sfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_port),
    .cfg     (cfg),
    .plen_wr (plen_wr)
  );

  sfr_matcher #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_matcher (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .plen_wr   (plen_wr),
    .fire      (fire),
    .text_byte (in_stream.text_byte),
    .text_end  (in_stream.text_end),
    .burst     (burst)
  );

  sfr_out_buf u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .burst    (burst),
    .in_ready (buf_ready),
    .out_ch   (out_stream)
  );

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stream.valid |-> in_stream.ready)
    else $error("input stalled with empty output buffer");

  a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_stream.valid && !out_stream.byte_valid |-> out_stream.run_last && out_stream.result_end)
    else $error("end marker not flagged as final");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_stream.valid && out_stream.result_end |-> out_stream.run_last)
    else $error("string end before last result of transfer");

  a_end_input_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    in_stream.valid && in_stream.ready && in_stream.text_end |=> out_stream.valid)
    else $error("string end gave no result");
`endif

endmodule

[tb/stream_find_replace_top_tb.sv]
`timescale 1ns / 1ps

module stream_find_replace_top_tb;

  localparam int MAX_PAT = sfr_pkg::MAX_PATTERN_DEF;
  localparam int DRAIN_CYCLES = 6;
  localparam int TIMEOUT_NS = 2_400_000;

  typedef struct packed {
    logic [7:0] rbyte;
    logic       bval;
    logic       rlast;
    logic       rend;
  } res_t;

  typedef enum logic {ROW_CFG, ROW_TEXT} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    sfr_pkg::cfg_idx_t  idx;
    logic [63:0]        wdata;
    logic [7:0]         tbyte;
    logic               tend;
    bit                 typed;
    int                 typed_n;
    res_t               typed_res;
  } row_t;

  logic clk;
  logic rst_n;

  sfr_in_if  in_bus ();
  sfr_out_if out_bus ();
  sfr_cfg_if cfg_bus ();

  stream_find_replace_top #(.MAX_PATTERN(MAX_PAT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_bus),
    .out_stream (out_bus),
    .cfg_port   (cfg_bus)
  );

  // predictor state
  sfr_pkg::cfg_t shadow;
  logic [7:0]    win [8];
  int            win_cnt;
  res_t          burst_q [$];
  res_t          expected_results [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  in_open;
  bit  cfg_open;
  int  err_cnt;
  int  xfer_cnt;
  int  str_cnt;
  int  res_cnt;
  int  wr_cnt;
  row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("stream_find_replace_top_tb NOT OK");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic clear_window();
    for (int k = 0; k < 8; k++) win[k] = 8'h00;
    win_cnt = 0;
  endtask

  task automatic put_result(input logic [7:0] b);
    if (burst_q.size() < 8) burst_q.push_back('{b, 1'b1, 1'b0, 1'b0});
  endtask

  // results caused by one text byte, left in burst_q
  task automatic scan_byte(input logic [7:0] b, input logic e);
    int   plen;
    int   rlen;
    bit   hit;
    res_t tail;
    burst_q.delete();
    plen = (shadow.pattern_length > MAX_PAT) ? MAX_PAT : int'(shadow.pattern_length);
    rlen = (shadow.replacement_length > 8) ? 8 : int'(shadow.replacement_length);
    if (plen == 0) begin
      put_result(b);
    end else begin
      if (win_cnt < 8) begin
        win[win_cnt] = b;
        win_cnt++;
      end
      if (win_cnt >= plen) begin
        hit = 1'b1;
        for (int k = 0; k < plen; k++) begin
          if (win[k] != shadow.pattern_bytes[8*k +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (int k = 0; k < rlen; k++) put_result(shadow.replacement_bytes[8*k +: 8]);
          clear_window();
        end else begin
          put_result(win[0]);
          for (int k = 1; k < 8; k++) win[k-1] = win[k];
          win[7] = 8'h00;
          win_cnt--;
        end
      end
      if (e) begin
        for (int k = 0; k < win_cnt; k++) put_result(win[k]);
        clear_window();
      end
    end
    if (e && burst_q.size() == 0) burst_q.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
    if (burst_q.size() > 0) begin
      tail = burst_q.pop_back();
      tail.rlast = 1'b1;
      if (e) tail.rend = 1'b1;
      burst_q.push_back(tail);
    end
  endtask

  task automatic in_close();
    if (in_open) begin
      in_bus.valid <= 1'b0;
      in_open = 1'b0;
    end
  endtask

  task automatic cfg_close();
    if (cfg_open) begin
      cfg_bus.valid <= 1'b0;
      cfg_open = 1'b0;
    end
  endtask

  task automatic settle();
    in_close();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input sfr_pkg::cfg_idx_t idx, input logic [63:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.wdata <= v;
    cfg_open = 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    wr_cnt++;
    case (idx)
      sfr_pkg::CFG_PATTERN_BYTES:      shadow.pattern_bytes = v;
      sfr_pkg::CFG_PATTERN_LENGTH: begin
        shadow.pattern_length = v[sfr_pkg::LEN_W-1:0];
        clear_window();
      end
      sfr_pkg::CFG_REPLACEMENT_BYTES:  shadow.replacement_bytes = v;
      sfr_pkg::CFG_REPLACEMENT_LENGTH: shadow.replacement_length = v[sfr_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_text(input logic [7:0] b, input logic e, input bit typed,
                           input int typed_n, input res_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      in_open = 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.text_byte <= b;
    in_bus.text_end  <= e;
    in_open = 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    xfer_cnt++;
    if (e) str_cnt++;
    scan_byte(b, e);
    if (typed) begin
      if (typed_n == 1) expected_results.push_back(typed_res);
    end else begin
      foreach (burst_q[k]) expected_results.push_back(burst_q[k]);
    end
  endtask

  function automatic row_t cfg_row(input sfr_pkg::cfg_idx_t idx, input logic [63:0] v);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, wdata: v, tbyte: 8'h00, tend: 1'b0, typed: 1'b0,
          typed_n: 0, typed_res: '0};
    return r;
  endfunction

  function automatic row_t txt_row(input logic [7:0] b, input logic e);
    row_t r;
    r = '{kind: ROW_TEXT, idx: sfr_pkg::CFG_PATTERN_BYTES, wdata: '0, tbyte: b, tend: e,
          typed: 1'b0, typed_n: 0, typed_res: '0};
    return r;
  endfunction

  function automatic row_t chk_row(input logic [7:0] b, input logic e, input int n,
                                   input res_t res);
    row_t r;
    r = txt_row(b, e);
    r.typed     = 1'b1;
    r.typed_n   = n;
    r.typed_res = res;
    return r;
  endfunction

  task automatic set_config(input logic [63:0] pb, input logic [3:0] pl,
                            input logic [63:0] rb, input logic [3:0] rl);
    settle();
    write_reg(sfr_pkg::CFG_PATTERN_BYTES, pb);
    write_reg(sfr_pkg::CFG_PATTERN_LENGTH, {60'd0, pl});
    write_reg(sfr_pkg::CFG_REPLACEMENT_BYTES, rb);
    write_reg(sfr_pkg::CFG_REPLACEMENT_LENGTH, {60'd0, rl});
    cfg_close();
  endtask

  task automatic run_phase(input int mode, input int n_items);
    logic [7:0]  alpha [4];
    logic [7:0]  str [$];
    logic [63:0] pb;
    logic [63:0] rb;
    logic [3:0]  pl;
    logic [3:0]  rl;
    int eplen;
    int sent;
    int cut;
    int pick;
    int part;
    for (int k = 0; k < 4; k++) alpha[k] = 8'($urandom_range(255));
    pb = {$urandom, $urandom};
    rb = {$urandom, $urandom};
    case (mode)
      0: begin
        pl = 4'd1;
        rl = 4'd8;
      end
      1: begin
        pl = 4'd8;
        rl = 4'd0;
        pb = '1;
        alpha[0] = 8'hFF;
      end
      2: begin
        pl = 4'd0;
        rl = 4'($urandom_range(15));
      end
      3: begin
        pl = 4'd3;
        rl = 4'd8;
        pb = '0;
        rb = '1;
        alpha[0] = 8'h00;
      end
      default: begin
        pl = ($urandom_range(3) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 4));
        rl = 4'($urandom_range(15));
      end
    endcase
    eplen = (pl > MAX_PAT) ? MAX_PAT : int'(pl);
    if (mode != 1 && mode != 3) begin
      for (int k = 0; k < eplen; k++) pb[8*k +: 8] = alpha[$urandom_range(3)];
    end
    set_config(pb, pl, rb, rl);
    sent = 0;
    while (sent < n_items) begin
      str.delete();
      cut = $urandom_range(1, 10);
      while (str.size() < cut) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          for (int j = 0; j < eplen; j++) str.push_back(pb[8*j +: 8]);
        end else if (pick < 45 && eplen > 1) begin
          part = $urandom_range(1, eplen - 1);
          for (int j = 0; j < part; j++) str.push_back(pb[8*j +: 8]);
        end else if (pick < 90) begin
          str.push_back(alpha[$urandom_range(3)]);
        end else begin
          str.push_back(8'($urandom_range(255)));
        end
      end
      for (int j = 0; j < str.size(); j++) begin
        send_text(str[j], j == str.size() - 1, 1'b0, 0, '0);
      end
      sent += str.size();
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      res_cnt++;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result byte %02h", out_bus.result_byte));
      end else begin
        want = expected_results.pop_front();
        if (out_bus.result_byte !== want.rbyte)
          report($sformatf("result_byte %02h want %02h", out_bus.result_byte, want.rbyte));
        if (out_bus.byte_valid !== want.bval)
          report($sformatf("byte_valid %b want %b", out_bus.byte_valid, want.bval));
        if (out_bus.run_last !== want.rlast)
          report($sformatf("run_last %b want %b", out_bus.run_last, want.rlast));
        if (out_bus.result_end !== want.rend)
          report($sformatf("result_end %b want %b", out_bus.result_end, want.rend));
      end
    end
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.text_byte  = 8'h00;
    in_bus.text_end   = 1'b0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = sfr_pkg::CFG_PATTERN_BYTES;
    cfg_bus.wdata     = '0;
    shadow            = '0;
    send_idle_pct     = 23;
    recv_stall_pct    = 23;
    in_open           = 1'b0;
    cfg_open          = 1'b0;
    err_cnt           = 0;
    xfer_cnt          = 0;
    str_cnt           = 0;
    res_cnt           = 0;
    wr_cnt            = 0;
    clear_window();

    // pass-through after reset
    dir_rows.push_back(chk_row(8'h00, 1'b0, 1, '{8'h00, 1'b1, 1'b1, 1'b0}));
    dir_rows.push_back(chk_row(8'hFF, 1'b1, 1, '{8'hFF, 1'b1, 1'b1, 1'b1}));
    dir_rows.push_back(chk_row(8'h5A, 1'b1, 1, '{8'h5A, 1'b1, 1'b1, 1'b1}));
    // "ab" -> "XYZ"
    dir_rows.push_back(cfg_row(sfr_pkg::CFG_PATTERN_BYTES, 64'h6261));
    dir_rows.push_back(cfg_row(sfr_pkg::CFG_PATTERN_LENGTH, 64'd2));
    dir_rows.push_back(cfg_row(sfr_pkg::CFG_REPLACEMENT_BYTES, 64'h5A5958));
    dir_rows.push_back(cfg_row(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'd3));
    dir_rows.push_back(chk_row(8'h61, 1'b0, 0, '0));
    dir_rows.push_back(txt_row(8'h62, 1'b0));
    dir_rows.push_back(chk_row(8'h63, 1'b0, 0, '0));
    dir_rows.push_back(txt_row(8'h61, 1'b0));
    dir_rows.push_back(txt_row(8'h62, 1'b1));
    // deletion leaves only the end marker
    dir_rows.push_back(cfg_row(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'd0));
    dir_rows.push_back(chk_row(8'h61, 1'b0, 0, '0));
    dir_rows.push_back(chk_row(8'h62, 1'b1, 1, '{8'h00, 1'b0, 1'b1, 1'b1}));
    // oversized lengths clamp to eight
    dir_rows.push_back(cfg_row(sfr_pkg::CFG_PATTERN_BYTES, '1));
    dir_rows.push_back(cfg_row(sfr_pkg::CFG_PATTERN_LENGTH, 64'd15));
    dir_rows.push_back(cfg_row(sfr_pkg::CFG_REPLACEMENT_BYTES, 64'h0102030405060708));
    dir_rows.push_back(cfg_row(sfr_pkg::CFG_REPLACEMENT_LENGTH, 64'd15));
    for (int k = 0; k < 7; k++) dir_rows.push_back(txt_row(8'hFF, 1'b0));
    dir_rows.push_back(txt_row(8'hFF, 1'b1));
    dir_rows.push_back(chk_row(8'h00, 1'b1, 1, '{8'h00, 1'b1, 1'b1, 1'b1}));
    // length rewrite drops the held byte
    dir_rows.push_back(chk_row(8'h11, 1'b0, 0, '0));
    dir_rows.push_back(cfg_row(sfr_pkg::CFG_PATTERN_LENGTH, 64'd2));
    dir_rows.push_back(chk_row(8'h22, 1'b1, 1, '{8'h22, 1'b1, 1'b1, 1'b1}));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        if (!cfg_open) settle();
        write_reg(dir_rows[r].idx, dir_rows[r].wdata);
      end else begin
        cfg_close();
        send_text(dir_rows[r].tbyte, dir_rows[r].tend, dir_rows[r].typed,
                  dir_rows[r].typed_n, dir_rows[r].typed_res);
      end
    end

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 54;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 54;
        end
        default: begin
          send_idle_pct  = 23;
          recv_stall_pct = 23;
        end
      endcase
      run_phase(p < 4 ? p : 4, 28);
    end

    settle();
    $display("run covered %0d byte transfers in %0d strings, %0d results checked",
             xfer_cnt, str_cnt, res_cnt);
    $display("%0d register writes, %0d mismatches", wr_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("stream_find_replace_top_tb OK");
    end else begin
      $display("stream_find_replace_top_tb NOT OK");
    end
    $finish;
  end

endmodule
